/* src/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int ADDRESS_BITS_DEF  = 24;
	localparam int FIELD_BITS        = 24;

	localparam logic [FIELD_BITS-1:0] POOL_RESET = 24'd65536;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_NO_MATCH = 2'd2
	} status_t;

	// entry test applied to the beat coming back from the table
	typedef enum logic [1:0] {
		MATCH_FIT,
		MATCH_EMPTY,
		MATCH_START
	} match_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_FREE,
		WR_SPARE,
		WR_CHOSEN
	} wr_sel_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_SCAN,
		S_EMPTY_BEGIN,
		S_EMPTY_SCAN,
		S_WR_SPARE,
		S_WR_CHOSEN,
		S_FREE_SCAN
	} state_t;

	typedef struct packed {
		logic    load_req;
		logic    scan_begin;
		logic    scan_from_hit;
		logic    scan_run;
		match_t  match_mode;
		logic    latch_hit;
		logic    latch_spare;
		logic    clr_begin;
		wr_sel_t wr_sel;
		logic    res_valid;
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_last;
		logic clr_last;
		logic found;
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/ffba_ram.sv */
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/ffba_ctrl.sv */
`default_nettype none

module ffba_ctrl
	import ffba_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     func,
	input  wire logic     cfg_we,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy
);

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE) || cfg_we;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) state_d = S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_d = (func == FUNC_FREE) ? S_FREE_SCAN : S_ALLOC_SCAN;
				end
				S_ALLOC_SCAN: begin
					if (stat.hit) state_d = S_EMPTY_BEGIN;
					else if (stat.scan_last) state_d = S_IDLE;
				end
				S_EMPTY_BEGIN: begin
					state_d = S_EMPTY_SCAN;
				end
				S_EMPTY_SCAN: begin
					if (stat.hit) state_d = S_WR_SPARE;
					else if (stat.scan_last) state_d = S_WR_CHOSEN;
				end
				S_WR_SPARE: begin
					state_d = S_WR_CHOSEN;
				end
				S_WR_CHOSEN: begin
					state_d = S_IDLE;
				end
				S_FREE_SCAN: begin
					if (stat.scan_last) state_d = S_IDLE;
				end
				default: begin
					state_d = S_CLEAR;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		cmd = '{
			load_req:      1'b0,
			scan_begin:    1'b0,
			scan_from_hit: 1'b0,
			scan_run:      1'b0,
			match_mode:    MATCH_FIT,
			latch_hit:     1'b0,
			latch_spare:   1'b0,
			clr_begin:     1'b0,
			wr_sel:        WR_NONE,
			res_valid:     1'b0,
			res_status:    ST_DONE
		};
		if (cfg_we) begin
			cmd.clr_begin = 1'b1;
		end else begin
			case (state_q)
				S_CLEAR: begin
					cmd.wr_sel = WR_CLEAR;
				end
				S_IDLE: begin
					if (accept) begin
						cmd.load_req   = 1'b1;
						cmd.scan_begin = 1'b1;
					end
				end
				S_ALLOC_SCAN: begin
					cmd.scan_run   = 1'b1;
					cmd.match_mode = MATCH_FIT;
					cmd.latch_hit  = stat.hit;
					if (!stat.hit && stat.scan_last) begin
						cmd.res_valid  = 1'b1;
						cmd.res_status = ST_NO_FIT;
					end
				end
				S_EMPTY_BEGIN: begin
					cmd.scan_begin    = 1'b1;
					cmd.scan_from_hit = 1'b1;
				end
				S_EMPTY_SCAN: begin
					cmd.scan_run    = 1'b1;
					cmd.match_mode  = MATCH_EMPTY;
					cmd.latch_spare = stat.hit;
				end
				S_WR_SPARE: begin
					cmd.wr_sel = WR_SPARE;
				end
				S_WR_CHOSEN: begin
					cmd.wr_sel     = WR_CHOSEN;
					cmd.res_valid  = 1'b1;
					cmd.res_status = ST_DONE;
				end
				S_FREE_SCAN: begin
					cmd.scan_run   = 1'b1;
					cmd.match_mode = MATCH_START;
					if (stat.hit) cmd.wr_sel = WR_FREE;
					if (stat.scan_last) begin
						cmd.res_valid  = 1'b1;
						cmd.res_status = (stat.found || stat.hit) ? ST_DONE : ST_NO_MATCH;
					end
				end
				default: begin
					cmd.wr_sel = WR_NONE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/ffba_datapath.sv */
`default_nettype none

module ffba_datapath
	import ffba_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	input  wire logic                  func,
	input  wire logic [FIELD_BITS-1:0] amount,
	input  wire logic [FIELD_BITS-1:0] free_address,
	input  wire logic                  cfg_we,
	input  wire logic [FIELD_BITS-1:0] cfg_data,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [FIELD_BITS-1:0]      block_address
);

	localparam int AW = ADDRESS_BITS;
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int WW = 2 * AW + 1;
	localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);
	localparam logic [IW:0]   SCAN_END  = (IW + 1)'(TABLE_ENTRIES);

	// word layout: used, length, start
	logic [WW-1:0] rdata, wdata;
	logic [IW-1:0] waddr;
	logic          we, issue;
	logic [AW-1:0] rd_start, rd_len;
	logic          rd_used;

	logic          func_q;
	logic [AW-1:0] amt_q, faddr_q, base_q, len_q;
	logic [IW-1:0] hit_idx_q, spare_idx_q, clr_q, idx_s1;
	logic [IW:0]   rd_q;
	logic          vld_s1, spare_found_q, found_q;
	logic [FIELD_BITS-1:0] pool_q;

	logic          done_q;
	logic [1:0]    status_q;
	logic [FIELD_BITS-1:0] block_address_q;

	logic [63:0]   amount_wide, faddr_wide, pool_wide, base_wide;
	logic [AW-1:0] split_start, split_len, match_hit_unused;
	logic          cond;

	assign amount_wide = 64'(amount);
	assign faddr_wide  = 64'(free_address);
	assign pool_wide   = 64'(pool_q);
	assign base_wide   = 64'(base_q);

	assign rd_start = rdata[AW-1:0];
	assign rd_len   = rdata[2*AW-1:AW];
	assign rd_used  = rdata[2*AW];

	assign split_start = base_q + amt_q;
	assign split_len   = len_q - amt_q;
	assign match_hit_unused = '0;

	assign issue = cmd.scan_run && (rd_q < SCAN_END);

	ffba_ram #(
		.WIDTH(WW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (rd_q[IW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		case (cmd.match_mode)
			MATCH_FIT:   cond = !rd_used && (rd_len >= amt_q);
			MATCH_EMPTY: cond = !rd_used && (rd_len == match_hit_unused);
			MATCH_START: cond = (rd_start == faddr_q);
			default:     cond = 1'b0;
		endcase
	end

	assign stat.hit       = vld_s1 && cond;
	assign stat.scan_last = vld_s1 && (idx_s1 == LAST_IDX);
	assign stat.clr_last  = (clr_q == LAST_IDX);
	assign stat.found     = found_q;

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		case (cmd.wr_sel)
			WR_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = {1'b0, (clr_q == '0) ? pool_wide[AW-1:0] : {AW{1'b0}}, {AW{1'b0}}};
			end
			WR_FREE: begin
				we    = 1'b1;
				waddr = idx_s1;
				wdata = {1'b0, rd_len, rd_start};
			end
			WR_SPARE: begin
				we    = 1'b1;
				waddr = spare_idx_q;
				wdata = {1'b0, split_len, split_start};
			end
			WR_CHOSEN: begin
				// a spare landing on the chosen entry has already moved its start
				we    = 1'b1;
				waddr = hit_idx_q;
				wdata = {1'b1, amt_q,
					(spare_found_q && (spare_idx_q == hit_idx_q)) ? split_start : base_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q        <= POOL_RESET;
			clr_q         <= '0;
			rd_q          <= '0;
			vld_s1        <= 1'b0;
			spare_found_q <= 1'b0;
			found_q       <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) pool_q <= cfg_data;

			if (cmd.clr_begin) clr_q <= '0;
			else if (cmd.wr_sel == WR_CLEAR) clr_q <= clr_q + 1'b1;

			if (cmd.scan_begin) begin
				rd_q   <= cmd.scan_from_hit ? {1'b0, hit_idx_q} : '0;
				vld_s1 <= 1'b0;
			end else begin
				if (issue) rd_q <= rd_q + 1'b1;
				vld_s1 <= issue;
			end

			if (cmd.load_req) begin
				spare_found_q <= 1'b0;
				found_q       <= 1'b0;
			end else begin
				if (cmd.latch_spare) spare_found_q <= 1'b1;
				if (cmd.wr_sel == WR_FREE) found_q <= 1'b1;
			end

			done_q <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IW-1:0];
		if (cmd.load_req) begin
			func_q  <= func;
			amt_q   <= amount_wide[AW-1:0];
			faddr_q <= faddr_wide[AW-1:0];
		end
		if (cmd.latch_hit) begin
			hit_idx_q <= idx_s1;
			base_q    <= rd_start;
			len_q     <= rd_len;
		end
		if (cmd.latch_spare) spare_idx_q <= idx_s1;
		if (cmd.res_valid) begin
			status_q <= cmd.res_status;
			block_address_q <= (cmd.res_status == ST_DONE && func_q == FUNC_ALLOC)
				? base_wide[FIELD_BITS-1:0] : '0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign block_address = block_address_q;

endmodule

`default_nettype wire

/* src/first_fit_block_allocator.sv */
// channel   ports                                  handshake
// request   start, func, amount, free_address      taken when start && !busy
// result    done, status, block_address            one-cycle strobe on done
// config    cfg_we, cfg_data (pool_size)           written when cfg_we
//
// allocate: a first-fit pass through the descriptor ram and a spare-entry pass
// from the hit to the last entry
// free: one full pass with write-back of matches
// after reset and after each pool_size write a format pass over all TABLE_ENTRIES
// entries runs with busy high; results cannot be held off by the receiver
`default_nettype none

module first_fit_block_allocator
	import ffba_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  func,
	input  wire logic [FIELD_BITS-1:0] amount,
	input  wire logic [FIELD_BITS-1:0] free_address,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [FIELD_BITS-1:0]      block_address,
	input  wire logic                  cfg_we,
	input  wire logic [FIELD_BITS-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.cfg_we (cfg_we),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffba_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDRESS_BITS  (ADDRESS_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.amount        (amount),
		.free_address  (free_address),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.block_address (block_address)
	);

endmodule

`default_nettype wire
